FILE: src/period_follow_blinker_defines.svh
// Assertion macros used by the checker file of the blinker.
`ifndef PERIOD_FOLLOW_BLINKER_DEFINES_SVH
`define PERIOD_FOLLOW_BLINKER_DEFINES_SVH

// Assert a property on an explicit clock and active-low reset.
`define PFB_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Assert a property on the block clock and reset.
`define PFB_ASSERT(lbl, prop, msg) `PFB_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: src/pfb_pkg.sv
// Types and constants of the period-following blinker.
package pfb_pkg;

  localparam int unsigned FIELD_W = 13;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MIN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MAX   = 8'd3;

  localparam logic [FIELD_W-1:0] GLITCH_LOW_RST  = 13'd10;
  localparam logic [FIELD_W-1:0] GLITCH_HIGH_RST = 13'd5000;
  localparam logic [FIELD_W-1:0] BLINK_MIN_RST   = 13'd100;
  localparam logic [FIELD_W-1:0] BLINK_MAX_RST   = 13'd1000;
  localparam logic [FIELD_W-1:0] START_PERIOD    = 13'd500;

  typedef struct packed {
    logic [FIELD_W-1:0] glitch_low;
    logic [FIELD_W-1:0] glitch_high;
    logic [FIELD_W-1:0] blink_min;
    logic [FIELD_W-1:0] blink_max;
  } cfg_t;

  typedef struct packed {
    logic               led_on;
    logic [FIELD_W-1:0] blink_period;
    logic [FIELD_W-1:0] last_measure;
    logic               measure_taken;
  } res_t;

endpackage

FILE: src/period_follow_blinker.sv
// Top level of the period-following LED blinker.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   tick_i, rise_i
//   out      source     out_valid_o/out_ready_i led_on_o, blink_period_o,
//                                               last_measure_o, measure_taken_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per clock while in_ready_o is high; its result appears in the result register on the next cycle.
// Throughput is set by the single result register: it reloads in the cycle it empties.
// When the result is not taken, in_ready_o drops until out_ready_i returns.
// Reset clears the counters and LED, and loads the default bounds and a 500-tick period.
// Config writes are taken every cycle.
module period_follow_blinker import pfb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 tick_i,
  input  logic                 rise_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 led_on_o,
  output logic [FIELD_W-1:0]   blink_period_o,
  output logic [FIELD_W-1:0]   last_measure_o,
  output logic                 measure_taken_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FIELD_W-1:0]   cfg_data_i
);

  cfg_t cfg_q;
  res_t step_res;
  res_t out_res;
  logic fire;

  assign cfg_ready_o = 1'b1;

  // Unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glitch_low  <= GLITCH_LOW_RST;
      cfg_q.glitch_high <= GLITCH_HIGH_RST;
      cfg_q.blink_min   <= BLINK_MIN_RST;
      cfg_q.blink_max   <= BLINK_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GLITCH_LOW:  cfg_q.glitch_low  <= cfg_data_i;
        CFG_GLITCH_HIGH: cfg_q.glitch_high <= cfg_data_i;
        CFG_BLINK_MIN:   cfg_q.blink_min   <= cfg_data_i;
        CFG_BLINK_MAX:   cfg_q.blink_max   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fire = in_valid_i && in_ready_o;

  pfb_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .tick_i (tick_i),
    .rise_i (rise_i),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  pfb_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (step_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign led_on_o        = out_res.led_on;
  assign blink_period_o  = out_res.blink_period;
  assign last_measure_o  = out_res.last_measure;
  assign measure_taken_o = out_res.measure_taken;

endmodule

FILE: src/pfb_step.sv
// Per-beat state update: period measurement, clamping and LED toggle timer.
module pfb_step import pfb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 13
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  logic tick_i,
  input  logic rise_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;

  logic [COUNT_BITS-1:0] since_edge_q, since_edge_d, se_inc;
  logic [COUNT_BITS-1:0] since_toggle_q, since_toggle_d, st_inc;
  logic                  started_q, started_d;
  logic [FIELD_W-1:0]    accepted_q, accepted_d;
  logic [FIELD_W-1:0]    blink_q, blink_d;
  logic                  lamp_q, lamp_d;

  logic [CMP_W-1:0]   period_ext;
  logic [FIELD_W-1:0] period;
  logic [FIELD_W-1:0] clamped;
  logic               in_window;
  logic               taken;
  logic               toggle;

  // Saturating increments on a tick.
  always_comb begin
    se_inc = since_edge_q;
    st_inc = since_toggle_q;
    if (tick_i && (since_edge_q != {COUNT_BITS{1'b1}})) begin
      se_inc = since_edge_q + COUNT_BITS'(1);
    end
    if (tick_i && (since_toggle_q != {COUNT_BITS{1'b1}})) begin
      st_inc = since_toggle_q + COUNT_BITS'(1);
    end
  end

  assign period_ext = CMP_W'(se_inc);
  assign period     = period_ext[FIELD_W-1:0];
  assign in_window  = (period_ext > CMP_W'(cfg_i.glitch_low)) &&
                      (period_ext < CMP_W'(cfg_i.glitch_high));
  assign taken      = rise_i && started_q && in_window;

  // Lower bound is tested first, so crossed bounds favour blink_min.
  always_comb begin
    if (period < cfg_i.blink_min) begin
      clamped = cfg_i.blink_min;
    end else if (period > cfg_i.blink_max) begin
      clamped = cfg_i.blink_max;
    end else begin
      clamped = period;
    end
  end

  assign accepted_d = taken ? period : accepted_q;
  assign blink_d    = taken ? clamped : blink_q;
  assign started_d  = started_q | rise_i;
  assign since_edge_d = rise_i ? '0 : se_inc;

  assign toggle = CMP_W'(st_inc) >= CMP_W'(blink_d[FIELD_W-1:1]);
  assign lamp_d = lamp_q ^ toggle;
  assign since_toggle_d = toggle ? '0 : st_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_edge_q   <= '0;
      since_toggle_q <= '0;
      started_q      <= 1'b0;
      accepted_q     <= START_PERIOD;
      blink_q        <= START_PERIOD;
      lamp_q         <= 1'b0;
    end else if (fire_i) begin
      since_edge_q   <= since_edge_d;
      since_toggle_q <= since_toggle_d;
      started_q      <= started_d;
      accepted_q     <= accepted_d;
      blink_q        <= blink_d;
      lamp_q         <= lamp_d;
    end
  end

  assign res_o.led_on        = lamp_d;
  assign res_o.blink_period  = blink_d;
  assign res_o.last_measure  = accepted_d;
  assign res_o.measure_taken = taken;

endmodule

FILE: src/pfb_obuf.sv
// Result register with valid/ready hand-off to the output channel.
module pfb_obuf import pfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  logic fire;
  res_t res_q;

  // Take a new beat when the register is empty or the held result leaves in the same cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign valid_d    = fire || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: src/pfb_checker.sv
// Port-level checks of the blinker, bound to the top level.
`include "period_follow_blinker_defines.svh"

module pfb_checker import pfb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] blink_period_o,
  input logic [FIELD_W-1:0] last_measure_o,
  input logic               measure_taken_o
);

  // A free consumer must never stall the producer.
  `PFB_ASSERT(a_ready_follows, out_ready_i |-> in_ready_o, "input stalled with output free")
  // Every accepted beat shows a result on the next cycle.
  `PFB_ASSERT(a_result_next, (in_valid_i && in_ready_o) |=> out_valid_o, "result missing")
  // A stalled result holds.
  `PFB_ASSERT(a_hold_stalled, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(blink_period_o) && $stable(last_measure_o)), "stalled result changed")
  // An accepted period lies above a non-negative lower bound, so it is never zero.
  `PFB_ASSERT(a_taken_nonzero, (out_valid_o && measure_taken_o) |-> (last_measure_o != '0), "zero period taken")

endmodule

bind period_follow_blinker pfb_checker u_pfb_checker (.*);
